/* hdl/md2_pkg.sv */
package md2_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int WORK_BYTES  = 48;
    localparam int ROUND_COUNT = 18;

    localparam int WA_AW  = $clog2(WORK_BYTES);
    localparam int BLK_AW = $clog2(BLOCK_BYTES);
    localparam int RND_W  = $clog2(ROUND_COUNT);

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_md2_in;

    // digest byte request
    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } t_md2_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ABS_RD,
        ST_ABS_WR,
        ST_ABS_X,
        ST_CMP_RD,
        ST_CMP_RUN,
        ST_CK_RD,
        ST_CK_WR,
        ST_CK_X,
        ST_OUT_RD,
        ST_OUT_WAIT
    } t_state;

    // pi-derived substitution table
    localparam logic [7:0] PI_SBOX [256] = '{
        8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61, 8'd54, 8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19,
        8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202,
        8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229, 8'd18,
        8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63,
        8'd148, 8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33,
        8'd128, 8'd127, 8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39,
        8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209,
        8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198,
        8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
        8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2,
        8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28, 8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15,
        8'd85, 8'd71, 8'd163, 8'd35, 8'd221, 8'd81, 8'd175, 8'd58,
        8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82,
        8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57,
        8'd242, 8'd239, 8'd183, 8'd14, 8'd102, 8'd88, 8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10,
        8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26,
        8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17, 8'd131, 8'd20
    };

endpackage

/* hdl/md2_ram.sv */
module md2_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/md2_message_digest_top.sv */
// MD2 digest engine, one message byte per input request, each taken only once idle.
// Each absorbed byte passes through read, write and mix states; a full block adds a
// compression (one S-box step per cycle on the work-area memory port, 18 x 48 steps).
// Message end: pad bytes absorbed likewise, compression, checksum block load, then
// compression again, then 16 digest bytes as the output takes them, then a clear.
// Reset (synchronous, active low) starts a clearing pass of the chaining and
// checksum memories; no input request is taken until it finishes.
module md2_message_digest_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  md2_pkg::t_md2_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output md2_pkg::t_md2_out o_out_data
);

    import md2_pkg::*;

    localparam logic [WA_AW-1:0]  WA_LAST  = WA_AW'(WORK_BYTES - 1);
    localparam logic [RND_W-1:0]  RND_LAST = RND_W'(ROUND_COUNT - 1);
    localparam logic [BLK_AW-1:0] BLK_LAST = BLK_AW'(BLOCK_BYTES - 1);
    localparam logic [1:0]        SEG_CHAIN = 2'd0;
    localparam logic [1:0]        SEG_BLOCK = 2'd1;
    localparam logic [1:0]        SEG_MIX   = 2'd2;

    t_state r_state, n_state;

    logic [BLK_AW-1:0] r_fill;
    logic [BLK_AW-1:0] r_k;
    logic [WA_AW-1:0]  r_idx;
    logic [RND_W-1:0]  r_rnd;
    logic [7:0]        r_t;
    logic [7:0]        r_ck_t;
    logic [7:0]        r_byte;
    logic [7:0]        r_x;
    logic              r_end;
    logic              r_padding;
    logic              r_final;
    logic              r_out_valid;
    t_md2_out          r_out;

    // memory ports
    logic              wa_we, wa_re;
    logic [WA_AW-1:0]  wa_waddr, wa_raddr;
    logic [7:0]        wa_wdata, wa_rdata;
    logic              ck_we, ck_re;
    logic [BLK_AW-1:0] ck_waddr, ck_raddr;
    logic [7:0]        ck_wdata, ck_rdata;

    logic       w_accept;
    logic       w_out_free;
    logic       w_fill_wrap;
    logic       w_cmp_done;
    logic [7:0] w_cmp_new;
    logic [7:0] w_ck_new;
    logic [7:0] w_pad_after;
    logic [7:0] w_pad_now;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_fill_wrap = (r_fill == BLK_LAST);
    assign w_cmp_done  = (r_idx == WA_LAST) && (r_rnd == RND_LAST);
    assign w_cmp_new   = wa_rdata ^ PI_SBOX[r_t];
    assign w_ck_new    = ck_rdata ^ PI_SBOX[r_byte ^ r_ck_t];
    // pad value after this byte lands, and for the current fill
    assign w_pad_after = 8'(BLOCK_BYTES) - 8'(r_fill + 1'b1);
    assign w_pad_now   = 8'(BLOCK_BYTES) - 8'(r_fill);

    // work area: chaining bytes 0..15, block 16..31, mix 32..47
    md2_ram #(
        .DEPTH (WORK_BYTES),
        .WIDTH (8)
    ) u_wa_ram (
        .i_clk   (i_clk),
        .i_we    (wa_we),
        .i_waddr (wa_waddr),
        .i_wdata (wa_wdata),
        .i_re    (wa_re),
        .i_raddr (wa_raddr),
        .o_rdata (wa_rdata)
    );

    // running checksum
    md2_ram #(
        .DEPTH (BLOCK_BYTES),
        .WIDTH (8)
    ) u_ck_ram (
        .i_clk   (i_clk),
        .i_we    (ck_we),
        .i_waddr (ck_waddr),
        .i_wdata (ck_wdata),
        .i_re    (ck_re),
        .i_raddr (ck_raddr),
        .o_rdata (ck_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_k == BLK_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.byte_present || i_in_data.message_end) begin
                        n_state = ST_ABS_RD;
                    end
                end
            end
            ST_ABS_RD: n_state = ST_ABS_WR;
            ST_ABS_WR: n_state = ST_ABS_X;
            ST_ABS_X: begin
                priority if (w_fill_wrap)      n_state = ST_CMP_RD;
                else if (r_padding || r_end)   n_state = ST_ABS_RD;
                else                           n_state = ST_IDLE;
            end
            ST_CMP_RD: n_state = ST_CMP_RUN;
            ST_CMP_RUN: begin
                if (w_cmp_done) begin
                    priority if (r_final)   n_state = ST_OUT_RD;
                    else if (r_padding)     n_state = ST_CK_RD;
                    else if (r_end)         n_state = ST_ABS_RD;
                    else                    n_state = ST_IDLE;
                end
            end
            ST_CK_RD: n_state = ST_CK_WR;
            ST_CK_WR: n_state = ST_CK_X;
            ST_CK_X: begin
                n_state = (r_k == BLK_LAST) ? ST_CMP_RD : ST_CK_RD;
            end
            ST_OUT_RD: n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (w_out_free) begin
                    n_state = (r_k == BLK_LAST) ? ST_CLEAR : ST_OUT_RD;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory controls per state
    always_comb begin
        wa_we    = 1'b0;
        wa_waddr = '0;
        wa_wdata = '0;
        wa_re    = 1'b0;
        wa_raddr = '0;
        ck_we    = 1'b0;
        ck_waddr = '0;
        ck_wdata = '0;
        ck_re    = 1'b0;
        ck_raddr = '0;
        unique case (r_state)
            ST_CLEAR: begin
                wa_we    = 1'b1;
                wa_waddr = {SEG_CHAIN, r_k};
                ck_we    = 1'b1;
                ck_waddr = r_k;
            end
            ST_ABS_RD: begin
                wa_re    = 1'b1;
                wa_raddr = {SEG_CHAIN, r_fill};
                ck_re    = 1'b1;
                ck_raddr = r_fill;
            end
            ST_ABS_WR: begin
                wa_we    = 1'b1;
                wa_waddr = {SEG_BLOCK, r_fill};
                wa_wdata = r_byte;
                ck_we    = 1'b1;
                ck_waddr = r_fill;
                ck_wdata = w_ck_new;
            end
            ST_ABS_X: begin
                wa_we    = 1'b1;
                wa_waddr = {SEG_MIX, r_fill};
                wa_wdata = r_x;
            end
            ST_CMP_RD: begin
                wa_re    = 1'b1;
                wa_raddr = '0;
            end
            ST_CMP_RUN: begin
                // write back step k while fetching step k+1
                wa_we    = 1'b1;
                wa_waddr = r_idx;
                wa_wdata = w_cmp_new;
                wa_re    = 1'b1;
                wa_raddr = (r_idx == WA_LAST) ? '0 : r_idx + 1'b1;
            end
            ST_CK_RD: begin
                wa_re    = 1'b1;
                wa_raddr = {SEG_CHAIN, r_k};
                ck_re    = 1'b1;
                ck_raddr = r_k;
            end
            ST_CK_WR: begin
                wa_we    = 1'b1;
                wa_waddr = {SEG_BLOCK, r_k};
                wa_wdata = ck_rdata;
            end
            ST_CK_X: begin
                wa_we    = 1'b1;
                wa_waddr = {SEG_MIX, r_k};
                wa_wdata = r_x;
            end
            ST_OUT_RD: begin
                wa_re    = 1'b1;
                wa_raddr = {SEG_CHAIN, r_k};
            end
            ST_IDLE, ST_OUT_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_k         <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_rnd       <= '0;
            r_ck_t      <= '0;
            r_end       <= 1'b0;
            r_padding   <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // digest register: load into a free slot, drop once taken
            if (r_state == ST_OUT_WAIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == BLK_LAST) begin
                        r_fill    <= '0;
                        r_ck_t    <= '0;
                        r_end     <= 1'b0;
                        r_padding <= 1'b0;
                        r_final   <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_end <= i_in_data.message_end;
                        if (i_in_data.byte_present) begin
                            r_byte <= i_in_data.data_byte;
                        end else if (i_in_data.message_end) begin
                            r_byte    <= w_pad_now;
                            r_padding <= 1'b1;
                        end
                    end
                end
                ST_ABS_WR: begin
                    r_x    <= wa_rdata ^ r_byte;
                    r_ck_t <= w_ck_new;
                end
                ST_ABS_X: begin
                    r_fill <= r_fill + 1'b1;
                    // end of message seen: switch to padding once the byte is in
                    if (!w_fill_wrap && r_end && !r_padding) begin
                        r_byte    <= w_pad_after;
                        r_padding <= 1'b1;
                    end
                end
                ST_CMP_RD: begin
                    r_idx <= '0;
                    r_rnd <= '0;
                    r_t   <= '0;
                end
                ST_CMP_RUN: begin
                    if (r_idx == WA_LAST) begin
                        r_idx <= '0;
                        r_rnd <= r_rnd + 1'b1;
                        r_t   <= w_cmp_new + 8'(r_rnd);
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_t   <= w_cmp_new;
                    end
                    if (w_cmp_done) begin
                        r_k <= '0;
                        // block ended exactly with the last message byte
                        if (!r_final && !r_padding && r_end) begin
                            r_byte    <= 8'(BLOCK_BYTES);
                            r_padding <= 1'b1;
                        end
                    end
                end
                ST_CK_WR: begin
                    r_x <= ck_rdata ^ wa_rdata;
                end
                ST_CK_X: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == BLK_LAST) r_final <= 1'b1;
                end
                ST_OUT_WAIT: begin
                    if (w_out_free) begin
                        r_out.digest_byte <= wa_rdata;
                        r_out.digest_last <= (r_k == BLK_LAST);
                        r_k               <= r_k + 1'b1;
                    end
                end
                ST_ABS_RD, ST_CK_RD, ST_OUT_RD: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* tb/md2_digest_checker.sv */
// Watches both channels of the MD2 engine, keeps its own digest calculation
// and compares every digest byte that leaves the block.
module md2_digest_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  md2_pkg::t_md2_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  md2_pkg::t_md2_out i_out_data,
    output int                o_fail_count,
    output int                o_digests_pending
);

    import md2_pkg::*;

    // MD2 substitution table, entry 0 first
    localparam logic [0:255][7:0] MD2_SBOX = {
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

    localparam int REPORT_LIMIT = 10;

    // predicted engine state
    logic [7:0]   chain_st [BLOCK_BYTES];
    logic [7:0]   csum_st  [BLOCK_BYTES];
    logic [127:0] blk_buf;
    int           fill;

    t_md2_out digest_q [$];
    int       fail_count;
    t_md2_out got_byte;
    t_md2_out want_byte;

    assign o_fail_count      = fail_count;
    assign o_digests_pending = digest_q.size();

    function automatic void clear_digest_state();
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            chain_st[k] = 8'h00;
            csum_st[k]  = 8'h00;
        end
        blk_buf = '0;
        fill    = 0;
    endfunction

    // one compression of a 16-byte block, plus the checksum update
    function automatic void md2_compress(input logic [127:0] blk);
        logic [7:0] wa [WORK_BYTES];
        logic [7:0] t;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            wa[k]      = chain_st[k];
            wa[k + 16] = blk[8*k +: 8];
            wa[k + 32] = chain_st[k] ^ blk[8*k +: 8];
        end
        t = 8'h00;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int k = 0; k < WORK_BYTES; k++) begin
                wa[k] = wa[k] ^ MD2_SBOX[t];
                t     = wa[k];
            end
            t = t + 8'(r);
        end
        for (int k = 0; k < BLOCK_BYTES; k++)
            chain_st[k] = wa[k];
        t = csum_st[15];
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            csum_st[k] = csum_st[k] ^ MD2_SBOX[blk[8*k +: 8] ^ t];
            t          = csum_st[k];
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        blk_buf[8*fill +: 8] = b;
        fill = fill + 1;
        if (fill == BLOCK_BYTES) begin
            md2_compress(blk_buf);
            fill = 0;
        end
    endfunction

    // one accepted request: take the byte, and on message end queue the digest
    function automatic void take_request(input t_md2_in req);
        logic [7:0]   pad;
        logic [127:0] csum_blk;
        t_md2_out     d;
        if (req.byte_present)
            absorb_byte(req.data_byte);
        if (req.message_end) begin
            pad = 8'(BLOCK_BYTES - fill);
            for (int k = 0; k < pad; k++)
                absorb_byte(pad);
            for (int k = 0; k < BLOCK_BYTES; k++)
                csum_blk[8*k +: 8] = csum_st[k];
            md2_compress(csum_blk);
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                d.digest_byte = chain_st[k];
                d.digest_last = (k == BLOCK_BYTES - 1);
                digest_q.push_back(d);
            end
            clear_digest_state();
        end
    endfunction

    function automatic void note_failure(input string what);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s", $time, what);
        fail_count = fail_count + 1;
    endfunction

    initial begin
        fail_count = 0;
        clear_digest_state();
    end

    // compare departing digest bytes first, then predict from the new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_digest_state();
            digest_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got_byte = i_out_data;
                if (digest_q.size() == 0) begin
                    note_failure($sformatf("unexpected digest byte %02h last %b",
                                           got_byte.digest_byte, got_byte.digest_last));
                end else begin
                    want_byte = digest_q.pop_front();
                    if (got_byte.digest_byte !== want_byte.digest_byte ||
                        got_byte.digest_last !== want_byte.digest_last)
                        note_failure($sformatf(
                            "digest mismatch: expected %02h last %b, got %02h last %b",
                            want_byte.digest_byte, want_byte.digest_last,
                            got_byte.digest_byte, got_byte.digest_last));
                end
            end
            if (i_in_valid && i_in_ready)
                take_request(i_in_data);
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    import md2_pkg::*;

    localparam int TOTAL_ITEMS  = 430;
    localparam int TAIL_START   = 380;
    localparam int LIMIT_CYCLES = 5000000;
    localparam int DRAIN_CYCLES = 40;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_md2_in  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_md2_out out_data;

    int fail_count;
    int digests_pending;
    int cycle_count = 0;
    int sent_count  = 0;
    int tx_idle_pct = 0;
    bit quiet_tail  = 1'b0;

    int unsigned ready_stall = 0;
    bit          rx_stalls   = 1'b1;

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    md2_message_digest_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    md2_digest_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_out_data        (out_data),
        .o_fail_count      (fail_count),
        .o_digests_pending (digests_pending)
    );

    // digest side back-pressure: stall bursts, with stall-free stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0)
            rx_stalls <= ~rx_stalls;
        if (quiet_tail) begin
            ready_stall <= 0;
            out_ready   <= 1'b1;
        end else if (ready_stall != 0) begin
            ready_stall <= ready_stall - 1;
            out_ready   <= (ready_stall == 1);
        end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(1, 10);
            out_ready   <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // present one request, optionally after an idle burst, and wait for acceptance
    task automatic send_request(input logic [7:0] data, input logic present,
                                input logic last);
        int unsigned gap;
        t_md2_in     req;
        gap = 0;
        if (!quiet_tail && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.data_byte    = data;
        req.byte_present = present;
        req.message_end  = last;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one random message; empty requests are sprinkled in between bytes
    task automatic send_message(input int unsigned len, input bit end_on_byte);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(pick_byte(), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // run watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, ignored data, byte with end, block-aligned end
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
        for (int k = 0; k < 16; k++)
            send_request(8'(k * 17), 1'b1, k == 15);

        // random messages, mostly of 4 to 40 bytes, some short (0 to 3) or block-aligned
        while (sent_count < TOTAL_ITEMS) begin
            if (sent_count >= TAIL_START)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 40;
            endcase
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(0, 3);
                2:       len = 16 * $urandom_range(1, 2);
                default: len = $urandom_range(4, 40);
            endcase
            send_message(len, $urandom_range(0, 1));
        end
        in_valid <= 1'b0;

        // let the checker take the last request before watching its queue
        @(posedge clk);
        while (digests_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
